// ----- design/seg_isect_pkg.sv -----
// ----------------------------------------------------------------------------
// seg_isect_pkg
// Shared widths, types and helpers for the segment intersection block.
// ----------------------------------------------------------------------------
package seg_isect_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int W           = COORD_WIDTH;
    localparam int DW          = W + 1;          // coordinate difference
    localparam int PW          = 2 * DW;         // product of two differences
    localparam int DENW        = PW + 1;         // determinant
    localparam int XW          = 2 * W + 1;      // cross term of one segment
    localparam int NPW         = XW + DW;        // numerator partial product
    localparam int NW          = NPW + 1;        // numerator
    localparam int QW          = W + 1;          // quotient bits kept
    localparam int SW          = W + 2;          // signed quotient
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic signed [W-1:0] ax;
        logic signed [W-1:0] ay;
        logic signed [W-1:0] bx;
        logic signed [W-1:0] by_coord;
        logic signed [W-1:0] cx;
        logic signed [W-1:0] cy;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
    } coord_t;

    typedef struct packed {
        logic [NW-1:0]   nx_mag;
        logic [NW-1:0]   ny_mag;
        logic            nx_neg;
        logic            ny_neg;
        logic [DENW-1:0] den_mag;
        logic            den_zero;
        coord_t          crd;
    } item_t;

    typedef struct packed {
        logic [DENW-1:0] rx;
        logic [DENW-1:0] ry;
        logic [QW-1:0]   nlx;
        logic [QW-1:0]   nly;
        logic [QW-1:0]   qx;
        logic [QW-1:0]   qy;
        logic            nx_neg;
        logic            ny_neg;
        logic [DENW-1:0] den_mag;
        logic            ok;
        coord_t          crd;
    } dstage_t;

    function automatic logic in_span(logic signed [SW-1:0] v,
                                     logic signed [W-1:0] p,
                                     logic signed [W-1:0] s);
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        lo = (p < s) ? SW'(p) : SW'(s);
        hi = (p < s) ? SW'(s) : SW'(p);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

// ----- design/seg_isect_front.sv -----
// ----------------------------------------------------------------------------
// seg_isect_front
// Arithmetic front end: determinant, cross terms and numerators, six stages.
// ----------------------------------------------------------------------------
module seg_isect_front
    import seg_isect_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t in_crd,
    output logic   item_valid,
    input  logic   item_ready,
    output item_t  item
);

    logic [6:1] v_reg;
    logic [6:1] v_next;
    logic       en;

    coord_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic signed [DW-1:0] abx1_reg, aby1_reg, cdx1_reg, cdy1_reg;
    logic signed [DW-1:0] abx2_reg, aby2_reg, cdx2_reg, cdy2_reg;
    logic signed [DW-1:0] abx3_reg, aby3_reg, cdx3_reg, cdy3_reg;
    logic signed [PW-1:0] pd1_reg, pd2_reg;
    logic signed [2*W-1:0] pa_reg, pb_reg, pc_reg, pe_reg;
    logic signed [DENW-1:0] den3_reg, den4_reg, den5_reg;
    logic signed [XW-1:0] x1_reg, x2_reg;
    logic signed [NPW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;
    item_t item_reg;
    item_t item_next;

    assign en         = !v_reg[6] || item_ready;
    assign in_ready   = en;
    assign item_valid = v_reg[6];
    assign item       = item_reg;
    assign v_next     = {v_reg[5:1], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // quotient sign: numerator sign combined with determinant sign
    always_comb
    begin
        item_next.nx_neg   = nx_reg[NW-1] ^ den5_reg[DENW-1];
        item_next.ny_neg   = ny_reg[NW-1] ^ den5_reg[DENW-1];
        item_next.nx_mag   = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        item_next.ny_mag   = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
        item_next.den_mag  = den5_reg[DENW-1] ? DENW'(-den5_reg) : DENW'(den5_reg);
        item_next.den_zero = (den5_reg == '0);
        item_next.crd      = c5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= in_crd;
            abx1_reg <= DW'(in_crd.ax) - DW'(in_crd.bx);
            aby1_reg <= DW'(in_crd.ay) - DW'(in_crd.by_coord);
            cdx1_reg <= DW'(in_crd.cx) - DW'(in_crd.dx);
            cdy1_reg <= DW'(in_crd.cy) - DW'(in_crd.dy);

            c2_reg   <= c1_reg;
            abx2_reg <= abx1_reg;
            aby2_reg <= aby1_reg;
            cdx2_reg <= cdx1_reg;
            cdy2_reg <= cdy1_reg;
            pd1_reg  <= abx1_reg * cdy1_reg;
            pd2_reg  <= aby1_reg * cdx1_reg;
            pa_reg   <= c1_reg.ax * c1_reg.by_coord;
            pb_reg   <= c1_reg.ay * c1_reg.bx;
            pc_reg   <= c1_reg.cx * c1_reg.dy;
            pe_reg   <= c1_reg.cy * c1_reg.dx;

            c3_reg   <= c2_reg;
            abx3_reg <= abx2_reg;
            aby3_reg <= aby2_reg;
            cdx3_reg <= cdx2_reg;
            cdy3_reg <= cdy2_reg;
            den3_reg <= DENW'(pd1_reg) - DENW'(pd2_reg);
            x1_reg   <= XW'(pa_reg) - XW'(pb_reg);
            x2_reg   <= XW'(pc_reg) - XW'(pe_reg);

            c4_reg   <= c3_reg;
            den4_reg <= den3_reg;
            m1_reg   <= x1_reg * cdx3_reg;
            m2_reg   <= abx3_reg * x2_reg;
            m3_reg   <= x1_reg * cdy3_reg;
            m4_reg   <= aby3_reg * x2_reg;

            c5_reg   <= c4_reg;
            den5_reg <= den4_reg;
            nx_reg   <= NW'(m1_reg) - NW'(m2_reg);
            ny_reg   <= NW'(m3_reg) - NW'(m4_reg);

            item_reg <= item_next;
        end
    end

endmodule

// ----- design/seg_isect_fifo.sv -----
// ----------------------------------------------------------------------------
// seg_isect_fifo
// Short queue between front end and divider back end.
// ----------------------------------------------------------------------------
module seg_isect_fifo
    import seg_isect_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_data
);

    item_t mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic push;
    logic pop;

    assign wr_ready = (cnt_reg != FIFO_DEPTH[FIFO_AW:0]);
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/seg_isect_back.sv -----
// ----------------------------------------------------------------------------
// seg_isect_back
// Pipelined restoring divider, one quotient bit per stage, and box check.
// ----------------------------------------------------------------------------
module seg_isect_back
    import seg_isect_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic signed [W-1:0] ix,
    output logic signed [W-1:0] iy
);

    dstage_t st_reg  [QW+1];
    dstage_t st_next [QW+1];
    logic [QW:0] v_reg;
    logic        vo_reg;
    logic        hit_reg;
    logic signed [W-1:0] ix_reg, iy_reg;
    logic signed [SW-1:0] sx, sy;
    logic hit_next;
    logic en;
    logic ovx, ovy;

    assign en         = !vo_reg || out_ready;
    assign item_ready = en;
    assign out_valid  = vo_reg;
    assign hit        = hit_reg;
    assign ix         = ix_reg;
    assign iy         = iy_reg;

    always_comb
    begin
        ovx = DENW'(item.nx_mag[NW-1:QW]) >= item.den_mag;
        ovy = DENW'(item.ny_mag[NW-1:QW]) >= item.den_mag;
        st_next[0].rx      = DENW'(item.nx_mag[NW-1:QW]);
        st_next[0].ry      = DENW'(item.ny_mag[NW-1:QW]);
        st_next[0].nlx     = item.nx_mag[QW-1:0];
        st_next[0].nly     = item.ny_mag[QW-1:0];
        st_next[0].qx      = '0;
        st_next[0].qy      = '0;
        st_next[0].nx_neg  = item.nx_neg;
        st_next[0].ny_neg  = item.ny_neg;
        st_next[0].den_mag = item.den_mag;
        st_next[0].ok      = !item.den_zero && !ovx && !ovy;
        st_next[0].crd     = item.crd;
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        logic [DENW:0] tx, ty, dd;
        logic gex, gey;
        always_comb
        begin
            dd  = {1'b0, st_reg[k-1].den_mag};
            tx  = {st_reg[k-1].rx, st_reg[k-1].nlx[QW-1]};
            ty  = {st_reg[k-1].ry, st_reg[k-1].nly[QW-1]};
            gex = (tx >= dd);
            gey = (ty >= dd);
            st_next[k]     = st_reg[k-1];
            st_next[k].rx  = gex ? DENW'(tx - dd) : tx[DENW-1:0];
            st_next[k].ry  = gey ? DENW'(ty - dd) : ty[DENW-1:0];
            st_next[k].nlx = st_reg[k-1].nlx << 1;
            st_next[k].nly = st_reg[k-1].nly << 1;
            st_next[k].qx  = {st_reg[k-1].qx[QW-2:0], gex};
            st_next[k].qy  = {st_reg[k-1].qy[QW-2:0], gey};
        end
    end

    always_comb
    begin
        sx = st_reg[QW].nx_neg ? -$signed({1'b0, st_reg[QW].qx})
                               : $signed({1'b0, st_reg[QW].qx});
        sy = st_reg[QW].ny_neg ? -$signed({1'b0, st_reg[QW].qy})
                               : $signed({1'b0, st_reg[QW].qy});
        hit_next = st_reg[QW].ok
                && in_span(sx, st_reg[QW].crd.ax, st_reg[QW].crd.bx)
                && in_span(sy, st_reg[QW].crd.ay, st_reg[QW].crd.by_coord)
                && in_span(sx, st_reg[QW].crd.cx, st_reg[QW].crd.dx)
                && in_span(sy, st_reg[QW].crd.cy, st_reg[QW].crd.dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[QW-1:0], item_valid};
            vo_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            hit_reg <= hit_next;
            ix_reg  <= hit_next ? sx[W-1:0] : '0;
            iy_reg  <= hit_next ? sy[W-1:0] : '0;
        end
    end

endmodule

// ----- design/segment_intersection_top.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_top
// Integer segment intersection by the determinant formula.
//
// Input channel: in_valid/in_ready carry the endpoints of segments AB and CD
// (ax, ay, bx, by_coord, cx, cy, dx, dy). Output channel: out_valid/out_ready
// carry hit and the truncated intersection point ix, iy (zero when no hit).
// One result per input transfer, in order.
// One transfer per cycle while out_ready stays high. A result passes the
// multiply front end, the queue, the divider (one quotient bit per stage)
// and the output register.
// A four-entry queue separates front end and divider so each stalls alone.
// When the receiver holds out_ready low, the divider holds, the queue fills,
// then the front end holds and in_ready drops.
// Reset clears all valid flags and the queue; no result is pending after it.
// ----------------------------------------------------------------------------
module segment_intersection_top
    import seg_isect_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [W-1:0] ax,
    input  logic signed [W-1:0] ay,
    input  logic signed [W-1:0] bx,
    input  logic signed [W-1:0] by_coord,
    input  logic signed [W-1:0] cx,
    input  logic signed [W-1:0] cy,
    input  logic signed [W-1:0] dx,
    input  logic signed [W-1:0] dy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic signed [W-1:0] ix,
    output logic signed [W-1:0] iy
);

    coord_t in_crd;
    item_t  f_item, q_item;
    logic   f_valid, f_ready, q_valid, q_ready;

    always_comb
    begin
        in_crd.ax       = ax;
        in_crd.ay       = ay;
        in_crd.bx       = bx;
        in_crd.by_coord = by_coord;
        in_crd.cx       = cx;
        in_crd.cy       = cy;
        in_crd.dx       = dx;
        in_crd.dy       = dy;
    end

    seg_isect_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_crd     (in_crd),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    seg_isect_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_item)
    );

    seg_isect_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .ix         (ix),
        .iy         (iy)
    );

endmodule

// ----- tb/tb_segment_intersection_top.sv -----
// ----------------------------------------------------------------------------
// tb_segment_intersection_top
// Checks the segment intersection block against a behavioral predictor.
// Segment pairs go in over a valid/ready channel with random sender and
// receiver gaps; each result is compared field by field with the predicted
// hit flag and truncated intersection point.
// ----------------------------------------------------------------------------
module tb_segment_intersection_top;
    import seg_isect_pkg::*;

    typedef struct {
        logic                hit;
        logic signed [W-1:0] ix;
        logic signed [W-1:0] iy;
    } isect_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic signed [W-1:0] ax, ay, bx, by_coord, cx, cy, dx, dy;
    logic                out_valid;
    logic                out_ready;
    logic                hit;
    logic signed [W-1:0] ix, iy;

    isect_t      pending_q[$];
    int          errors;
    int          sent;
    int          received;
    int          hits;
    int          cycles;
    int unsigned send_gap_pct;
    int unsigned recv_gap_pct;

    localparam int CYCLE_LIMIT = 400000;

    segment_intersection_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ax       (ax),
        .ay       (ay),
        .bx       (bx),
        .by_coord (by_coord),
        .cx       (cx),
        .cy       (cy),
        .dx       (dx),
        .dy       (dy),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit      (hit),
        .ix       (ix),
        .iy       (iy)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic in_box(longint v, longint p, longint s);
        longint lo;
        longint hi;
        lo = (p < s) ? p : s;
        hi = (p < s) ? s : p;
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic isect_t predict_isect(longint pax, longint pay, longint pbx,
                                             longint pby, longint pcx, longint pcy,
                                             longint pdx, longint pdy);
        isect_t r;
        longint abx, aby, cdx, cdy, den, x1, x2;
        logic signed [127:0] nx, ny, qx, qy;
        r.hit = 1'b0;
        r.ix  = '0;
        r.iy  = '0;
        abx = pax - pbx;
        aby = pay - pby;
        cdx = pcx - pdx;
        cdy = pcy - pdy;
        den = abx * cdy - aby * cdx;
        x1  = pax * pby - pay * pbx;
        x2  = pcx * pdy - pcy * pdx;
        if (den != 0)
        begin
            nx = 128'(x1) * 128'(cdx) - 128'(abx) * 128'(x2);
            ny = 128'(x1) * 128'(cdy) - 128'(aby) * 128'(x2);
            qx = nx / 128'(den);
            qy = ny / 128'(den);
            if (qx >= -(128'sd1 <<< 40) && qx <= (128'sd1 <<< 40) &&
                qy >= -(128'sd1 <<< 40) && qy <= (128'sd1 <<< 40))
            begin
                if (in_box(longint'(qx), pax, pbx) && in_box(longint'(qy), pay, pby) &&
                    in_box(longint'(qx), pcx, pdx) && in_box(longint'(qy), pcy, pdy))
                begin
                    r.hit = 1'b1;
                    r.ix  = qx[W-1:0];
                    r.iy  = qy[W-1:0];
                end
            end
        end
        return r;
    endfunction

    task automatic send_pair(input logic signed [W-1:0] pax, pay, pbx, pby,
                             input logic signed [W-1:0] pcx, pcy, pdx, pdy);
        logic taken;
        while (($urandom % 100) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ax <= pax; ay <= pay; bx <= pbx; by_coord <= pby;
        cx <= pcx; cy <= pcy; dx <= pdx; dy <= pdy;
        pending_q = {pending_q, predict_isect(pax, pay, pbx, pby, pcx, pcy, pdx, pdy)};
        // in_ready comes from registers only: sample it between edges
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        sent++;
    endtask

    function automatic logic signed [W-1:0] rnd_coord();
        case ($urandom_range(0, 3))
            0:       return W'($urandom);
            1:       return W'($signed($urandom_range(0, 64)) - 32);
            2:       return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return W'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic test_extremes();
        send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                  16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_pair(-16'sd10, 0, 10, 0, 0, -10, 0, 10);
        send_pair(0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 16'sh7fff);
        send_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_pair(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_pair(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
                  16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555);
    endtask

    task automatic test_zero_determinant();
        send_pair(0, 0, 10, 10, 1, 0, 11, 10);
        send_pair(0, 0, 10, 10, 20, 20, 30, 30);
        send_pair(0, 0, 10, 0, 5, 0, 20, 0);
        send_pair(5, 5, 5, 5, 0, 0, 10, 10);
    endtask

    task automatic test_outside_box();
        send_pair(0, 0, 10, 0, 20, -5, 20, 5);
        send_pair(0, 0, 1, 1, 100, 0, 101, 2);
        send_pair(0, 0, 1, 16'sh7fff, 1, 0, 2, 16'sh7fff);
        send_pair(0, 0, 7, 3, 0, 3, 7, 0);
        send_pair(-7, -3, 0, 0, -7, 0, 0, -3);
        send_pair(0, 0, 10, 0, 10, 0, 10, 10);
        send_pair(16'sh8000, 0, 16'sh7fff, 1, 0, 16'sh8000, 1, 16'sh7fff);
    endtask

    task automatic test_random(input int n);
        logic signed [W-1:0] p[8];
        logic signed [W-1:0] mx, my;
        for (int i = 0; i < n; i++)
        begin
            foreach (p[k])
                p[k] = rnd_coord();
            if ($urandom_range(0, 1))
            begin
                mx = W'($signed($urandom_range(0, 4000)) - 2000);
                my = W'($signed($urandom_range(0, 4000)) - 2000);
                p[2] = W'(2 * mx - p[0]);
                p[3] = W'(2 * my - p[1]);
                p[6] = W'(2 * mx - p[4]);
                p[7] = W'(2 * my - p[5]);
                if ((p[0] > 16000 || p[0] < -16000) || (p[1] > 16000 || p[1] < -16000))
                begin
                    p[0] = W'($signed($urandom_range(0, 4000)) - 2000);
                    p[1] = W'($signed($urandom_range(0, 4000)) - 2000);
                    p[2] = W'(2 * mx - p[0]);
                    p[3] = W'(2 * my - p[1]);
                end
                if ((p[4] > 16000 || p[4] < -16000) || (p[5] > 16000 || p[5] < -16000))
                begin
                    p[4] = W'($signed($urandom_range(0, 4000)) - 2000);
                    p[5] = W'($signed($urandom_range(0, 4000)) - 2000);
                    p[6] = W'(2 * mx - p[4]);
                    p[7] = W'(2 * my - p[5]);
                end
            end
            send_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
        end
    endtask

    // outputs are registered: check between edges the transfer of the next edge
    always @(negedge clk)
    begin
        isect_t e;
        if (rst_n && out_valid && out_ready)
        begin
            received++;
            if (pending_q.size() == 0)
            begin
                $error("result with none expected: hit=%0d ix=%0d iy=%0d", hit, ix, iy);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (hit !== e.hit)
                begin
                    $error("hit: expected %0d, actual %0d", e.hit, hit);
                    errors++;
                end
                if (ix !== e.ix)
                begin
                    $error("ix: expected %0d, actual %0d", e.ix, ix);
                    errors++;
                end
                if (iy !== e.iy)
                begin
                    $error("iy: expected %0d, actual %0d", e.iy, iy);
                    errors++;
                end
                if (e.hit)
                    hits++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= (($urandom % 100) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0; sent = 0; received = 0; hits = 0; cycles = 0;
        send_gap_pct = 6;
        recv_gap_pct = 68;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {ax, ay, bx, by_coord, cx, cy, dx, dy} = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_zero_determinant();
        test_outside_box();
        test_random(480);
        send_gap_pct = 68;
        recv_gap_pct = 6;
        test_random(480);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random(480);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d segment pairs, checked %0d results, %0d of them hits.",
                 sent, received, hits);
        $display("Covered corner coordinates, parallel lines, misses and random pairs.");
        if (errors == 0 && pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/seg_isect_pkg.sv
design/seg_isect_front.sv
design/seg_isect_fifo.sv
design/seg_isect_back.sv
design/segment_intersection_top.sv
tb/tb_segment_intersection_top.sv
